// ===== rtl/ddsc_pkg.sv =====
`default_nettype none

package ddsc_pkg;

  // stream packing
  localparam int PD_W    = 25;
  localparam int SER_W   = 17;
  localparam int TDATA_W = 48;

  // calendar constants
  localparam logic [11:0] BASE_YEAR  = 12'd1900;
  localparam logic [11:0] LAST_YEAR  = 12'd2099;
  localparam logic [16:0] MAX_SERIAL = 17'd73050;
  localparam logic [16:0] CYCLE_DAYS = 17'd1461;

  // reciprocals: q0 = (x * R) >> S is the true quotient or one below it
  localparam logic [21:0] RECIP_10000 = 22'd3435973;  // 2^35 / 10000
  localparam logic [13:0] RECIP_100   = 14'd10485;    // 2^20 / 100
  localparam logic [16:0] RECIP_1461  = 17'd91866;    // just below 2^27 / 1461

  typedef enum logic {
    ACT_TO_SERIAL = 1'b0,
    ACT_TO_DATE   = 1'b1
  } act_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
    logic s5_en;
  } ctl_t;

  typedef struct packed {
    act_t        act;
    logic [24:0] pd;
    logic [16:0] t;
    logic        sbad;
    logic [11:0] yq;
    logic [6:0]  nq;
  } s1_t;

  typedef struct packed {
    act_t        act;
    logic [11:0] year;
    logic [13:0] rem;
    logic [6:0]  ncyc;
    logic [10:0] rcyc;
    logic        sbad;
  } s2_t;

  typedef struct packed {
    act_t        act;
    logic        ybad;
    logic [7:0]  yoff;
    logic [13:0] rem;
    logic [6:0]  mq;
    logic [6:0]  ncyc;
    logic [1:0]  m;
    logic [8:0]  dl;
    logic        sbad;
  } s3_t;

  typedef struct packed {
    act_t        act;
    logic        bad;
    logic [7:0]  yoff;
    logic [3:0]  dmon;
    logic [4:0]  dday;
    logic [6:0]  ncyc;
    logic [1:0]  m;
    logic [3:0]  smon;
    logic [4:0]  sday;
  } s4_t;

  // days before month mon (1..12), leap day counted from March on
  function automatic logic [8:0] days_before(input logic [3:0] mon, input logic leap);
    logic [3:0] idx;
    logic [8:0] d;
    idx = mon - 4'd1;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && idx >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ddsc_divide.sv =====
`default_nettype none

module ddsc_divide
  import ddsc_pkg::*;
(
  input  wire logic        clk,
  input  wire ctl_t        ctl,
  input  wire act_t        action,
  input  wire logic [24:0] packed_date,
  input  wire logic [16:0] day_serial,
  output s2_t              s2
);

  s1_t s1;
  s1_t s1_next;
  s2_t s2_next;

  logic [46:0] ymul0;
  logic [33:0] nmul0;
  logic [16:0] t0;
  logic [25:0] ymul;
  logic [25:0] yrem;
  logic [16:0] nmul;
  logic [16:0] nrem;

  // stage 1: reciprocal estimates of yyyymmdd / 10000 and (serial-1) / 1461
  always_comb begin
    t0    = day_serial - 17'd1;
    ymul0 = 47'(packed_date) * 47'(RECIP_10000);
    nmul0 = 34'(t0) * 34'(RECIP_1461);
    s1_next.act  = action;
    s1_next.pd   = packed_date;
    s1_next.t    = t0;
    s1_next.sbad = (day_serial == 17'd0) || (day_serial > MAX_SERIAL);
    s1_next.yq   = ymul0[46:35];
    s1_next.nq   = nmul0[33:27];
  end

  // stage 2: back-multiply, one correction step each
  always_comb begin
    ymul = 26'(s1.yq) * 26'd10000;
    yrem = 26'(s1.pd) - ymul;
    nmul = 17'(s1.nq) * CYCLE_DAYS;
    nrem = s1.t - nmul;
    s2_next.act  = s1.act;
    s2_next.sbad = s1.sbad;
    if (yrem >= 26'd10000) begin
      s2_next.year = s1.yq + 12'd1;
      s2_next.rem  = 14'(yrem - 26'd10000);
    end else begin
      s2_next.year = s1.yq;
      s2_next.rem  = 14'(yrem);
    end
    if (nrem >= CYCLE_DAYS) begin
      s2_next.ncyc = s1.nq + 7'd1;
      s2_next.rcyc = 11'(nrem - CYCLE_DAYS);
    end else begin
      s2_next.ncyc = s1.nq;
      s2_next.rcyc = 11'(nrem);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      s1 <= s1_next;
    end
    if (ctl.s2_en) begin
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ddsc_locate.sv =====
`default_nettype none

module ddsc_locate
  import ddsc_pkg::*;
(
  input  wire logic clk,
  input  wire ctl_t ctl,
  input  wire s2_t  s2,
  output s4_t       s4
);

  s3_t s3;
  s3_t s3_next;
  s4_t s4_next;

  logic [26:0] mmul;
  logic [13:0] dmul;
  logic [13:0] drem;
  logic [6:0]  mon7;
  logic [6:0]  day7;
  logic        dbad;
  logic        leap;
  logic [3:0]  smon;
  logic [8:0]  sdb;

  // stage 3: month estimate, year within the four-year cycle
  always_comb begin
    mmul = 27'(s2.rem) * 27'(RECIP_100);
    s3_next.act  = s2.act;
    s3_next.ybad = (s2.year < BASE_YEAR) || (s2.year > LAST_YEAR);
    s3_next.yoff = 8'(s2.year - BASE_YEAR);
    s3_next.rem  = s2.rem;
    s3_next.mq   = mmul[26:20];
    s3_next.ncyc = s2.ncyc;
    s3_next.sbad = s2.sbad;
    if (s2.rcyc < 11'd366) begin
      s3_next.m  = 2'd0;
      s3_next.dl = 9'(s2.rcyc + 11'd1);
    end else if (s2.rcyc < 11'd731) begin
      s3_next.m  = 2'd1;
      s3_next.dl = 9'(s2.rcyc - 11'd365);
    end else if (s2.rcyc < 11'd1096) begin
      s3_next.m  = 2'd2;
      s3_next.dl = 9'(s2.rcyc - 11'd730);
    end else begin
      s3_next.m  = 2'd3;
      s3_next.dl = 9'(s2.rcyc - 11'd1095);
    end
  end

  // stage 4: month/day split and range check; month search for the serial
  always_comb begin
    dmul = 14'(s3.mq) * 14'd100;
    drem = s3.rem - dmul;
    if (drem >= 14'd100) begin
      mon7 = s3.mq + 7'd1;
      day7 = 7'(drem - 14'd100);
    end else begin
      mon7 = s3.mq;
      day7 = 7'(drem);
    end
    dbad = s3.ybad || (mon7 == 7'd0) || (mon7 > 7'd12) || (day7 == 7'd0) || (day7 > 7'd31);

    leap = (s3.m == 2'd0);
    smon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s3.dl > days_before(4'(k), leap)) begin
        smon = 4'(k);
      end
    end
    sdb = days_before(smon, leap);

    s4_next.act  = s3.act;
    s4_next.bad  = (s3.act == ACT_TO_DATE) ? s3.sbad : dbad;
    s4_next.yoff = s3.yoff;
    s4_next.dmon = mon7[3:0];
    s4_next.dday = day7[4:0];
    s4_next.ncyc = s3.ncyc;
    s4_next.m    = s3.m;
    s4_next.smon = smon;
    s4_next.sday = 5'(s3.dl - sdb);
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      s3 <= s3_next;
    end
    if (ctl.s4_en) begin
      s4 <= s4_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ddsc_assemble.sv =====
`default_nettype none

module ddsc_assemble
  import ddsc_pkg::*;
(
  input  wire logic  clk,
  input  wire ctl_t  ctl,
  input  wire s4_t   s4,
  output logic [16:0] serial_out,
  output logic [24:0] date_out,
  output logic        bad_input
);

  logic [16:0] serial_out_next;
  logic [24:0] date_out_next;
  logic [5:0]  ncyc_d;
  logic [1:0]  m_d;
  logic [16:0] cyc_days;
  logic [10:0] yr_days;
  logic [11:0] year_s;
  logic [25:0] ymul;

  always_comb begin
    // date to serial
    ncyc_d   = s4.yoff[7:2];
    m_d      = s4.yoff[1:0];
    cyc_days = 17'(ncyc_d) * CYCLE_DAYS;
    yr_days  = (m_d == 2'd0) ? 11'd0 : 11'(11'(m_d) * 11'd365 + 11'd1);
    // serial to date
    year_s   = BASE_YEAR + {3'b0, s4.ncyc, 2'b00} + 12'(s4.m);
    ymul     = 26'(year_s) * 26'd10000;

    serial_out_next = '0;
    date_out_next   = '0;
    if (!s4.bad) begin
      if (s4.act == ACT_TO_SERIAL) begin
        serial_out_next = cyc_days + 17'(yr_days)
                        + 17'(days_before(s4.dmon, m_d == 2'd0)) + 17'(s4.dday);
      end else begin
        date_out_next = 25'(ymul + 26'(s4.smon) * 26'd100 + 26'(s4.sday));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s5_en) begin
      serial_out <= serial_out_next;
      date_out   <= date_out_next;
      bad_input  <= s4.bad;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/date_day_serial_converter_unit.sv =====
// An accepted input word passes through registered stages s1 to s5 to its result word on m_*.
// Throughput: one word per cycle; every stage holds while the one after it is
// full and stalled, so s_tready falls only when the whole pipe is backed up.
// Reset: rst (synchronous) clears the stage valid bits only; datapath
// registers are not reset.
`default_nettype none

module date_day_serial_converter_unit
  import ddsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [TDATA_W-1:0]  s_tdata,   // [24:0] packed_date, [41:25] day_serial, pad
  input  wire logic                s_tuser,   // [0] action
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [TDATA_W-1:0]       m_tdata,   // [16:0] serial_out, [41:17] date_out, pad
  output logic                     m_tuser    // [0] bad_input
);

  // Pipeline:
  //   s1  reciprocal estimates of yyyymmdd/10000 and (serial-1)/1461
  //   s2  back-multiply and one-step correction -> year, mmdd, cycle, day in cycle
  //   s3  month estimate; year within the cycle by compares at 366/731/1096
  //   s4  month/day correction and range check; month search over the table
  //   s5  final sums into the output register

  ctl_t        ctl;
  logic [4:0]  valid;   // bit k: stage k+1 holds a word
  s2_t         s2;
  s4_t         s4;
  logic [16:0] serial_out;
  logic [24:0] date_out;
  logic        bad_input;

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    ctl.s5_en = !valid[4] || m_tready;
    ctl.s4_en = !valid[3] || ctl.s5_en;
    ctl.s3_en = !valid[2] || ctl.s4_en;
    ctl.s2_en = !valid[1] || ctl.s3_en;
    ctl.s1_en = !valid[0] || ctl.s2_en;
  end

  assign s_tready = ctl.s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.s1_en) valid[0] <= s_tvalid;
      if (ctl.s2_en) valid[1] <= valid[0];
      if (ctl.s3_en) valid[2] <= valid[1];
      if (ctl.s4_en) valid[3] <= valid[2];
      if (ctl.s5_en) valid[4] <= valid[3];
    end
  end

  ddsc_divide u_divide (
    .clk         (clk),
    .ctl         (ctl),
    .action      (act_t'(s_tuser)),
    .packed_date (s_tdata[PD_W-1:0]),
    .day_serial  (s_tdata[PD_W+SER_W-1:PD_W]),
    .s2          (s2)
  );

  ddsc_locate u_locate (
    .clk (clk),
    .ctl (ctl),
    .s2  (s2),
    .s4  (s4)
  );

  ddsc_assemble u_assemble (
    .clk        (clk),
    .ctl        (ctl),
    .s4         (s4),
    .serial_out (serial_out),
    .date_out   (date_out),
    .bad_input  (bad_input)
  );

  assign m_tvalid = valid[4];
  assign m_tdata  = {{(TDATA_W-SER_W-PD_W){1'b0}}, date_out, serial_out};
  assign m_tuser  = bad_input;

`ifndef SYNTHESIS
  // a rejected word carries zero results
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad word with non-zero result");

  // a good serial never exceeds the last day of 2099
  a_serial_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[SER_W-1:0] <= MAX_SERIAL)
    else $error("serial result out of range");

  // an empty pipe always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    valid == '0 |-> s_tready)
    else $error("empty pipe not ready");

  // only one of the two results may be non-zero
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[SER_W-1:0] == '0) || (m_tdata[PD_W+SER_W-1:SER_W] == '0))
    else $error("both results non-zero");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ddsc_pkg::*;

  // run shape
  localparam int RAND_WORDS  = 1000;
  localparam int QUIET_TAIL  = 150;     // last words go with no idling
  localparam int DRAIN_EVERY = 300;     // sender waits for all results now and then
  localparam int TAIL_CYCLES = 20;      // pipe is five deep; leave margin for strays
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 40;

  // one input word as the sender sees it
  typedef struct {
    act_t        act;
    logic [24:0] pd;
    logic [16:0] ser;
    bit          drain;   // wait until every result is back before sending
  } word_t;

  // one expected result word
  typedef struct {
    act_t        act;
    logic [16:0] serial;
    logic [24:0] date;
    logic        bad;
  } conv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;   // [24:0] packed_date, [41:25] day_serial, pad
  logic               s_tuser  = 1'b0; // [0] action
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;         // [16:0] serial_out, [41:17] date_out, pad
  logic               m_tuser;         // [0] bad_input

  word_t pend_q[$];
  conv_t conv_q[$];
  word_t cur;

  int sent_cnt = 0;
  int got_cnt  = 0;
  int err_cnt  = 0;
  int cycles   = 0;
  int src_gap  = 0;
  int snk_gap  = 0;
  bit quiet    = 1'b0;
  int n_to_ser = 0;
  int n_to_date = 0;
  int n_bad    = 0;

  date_day_serial_converter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Calendar predictor. 1900 is taken as a leap year, so every year from 1900
  // to 2099 falls in a 1461-day four-year cycle that opens with a leap year.
  // -------------------------------------------------------------------------

  // days in the year before the first of month mon
  function automatic int unsigned days_ahead(int unsigned mon, bit leap);
    int unsigned d;
    case (mon)
      1:       d = 0;
      2:       d = 31;
      3:       d = 59;
      4:       d = 90;
      5:       d = 120;
      6:       d = 151;
      7:       d = 181;
      8:       d = 212;
      9:       d = 243;
      10:      d = 273;
      11:      d = 304;
      default: d = 334;
    endcase
    if (leap && mon >= 3) begin
      d = d + 1;
    end
    return d;
  endfunction

  function automatic conv_t convert_date(word_t w);
    conv_t       r;
    int unsigned yr, mo, dy, yoff, t, rem, yic, dl, mon;
    r.act    = w.act;
    r.serial = '0;
    r.date   = '0;
    r.bad    = 1'b0;
    if (w.act == ACT_TO_SERIAL) begin
      yr = w.pd / 10000;
      mo = (w.pd % 10000) / 100;
      dy = w.pd % 100;
      // day is range-checked only, not against the month's length
      if (yr < 1900 || yr > 2099 || mo < 1 || mo > 12 || dy < 1 || dy > 31) begin
        r.bad = 1'b1;
      end else begin
        yoff = yr - 1900;
        t = (yoff / 4) * 1461;
        if (yoff % 4 != 0) begin
          t = t + (yoff % 4) * 365 + 1;
        end
        t = t + days_ahead(mo, yoff % 4 == 0) + dy;
        r.serial = t[16:0];
      end
    end else begin
      if (w.ser < 1 || w.ser > 73050) begin
        r.bad = 1'b1;
      end else begin
        t   = w.ser - 1;
        rem = t % 1461;
        // integer bounds keep 31 December in its own year
        if (rem < 366) begin
          yic = 0; dl = rem + 1;
        end else if (rem < 731) begin
          yic = 1; dl = rem - 365;
        end else if (rem < 1096) begin
          yic = 2; dl = rem - 730;
        end else begin
          yic = 3; dl = rem - 1095;
        end
        mon = 12;
        while (mon > 1 && dl <= days_ahead(mon, yic == 0)) begin
          mon = mon - 1;
        end
        t = (1900 + (t / 1461) * 4 + yic) * 10000 + mon * 100
            + (dl - days_ahead(mon, yic == 0));
        r.date = t[24:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt = err_cnt + 1;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: walks pend_q, one word per free slot. A word held on s_* stays
  // put until taken. Its expectation is queued at the edge it is accepted.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        conv_q.insert(conv_q.size(), convert_date(cur));
        sent_cnt <= sent_cnt + 1;
      end
      quiet <= pend_q.size() < QUIET_TAIL;
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pend_q[0].drain && (s_tvalid || sent_cnt != got_cnt)) begin
          // hold off until the pipe has emptied
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          src_gap  <= $urandom_range(1, 19) - 1;
          s_tvalid <= 1'b0;
        end else begin
          cur      = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, cur.ser, cur.pd};
          s_tuser  <= cur.act;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each accepted result word against the oldest expectation
  // and throttles m_tready in random bursts.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    conv_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_cnt <= got_cnt + 1;
        if (conv_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, tdata %h", m_tdata));
        end else begin
          e = conv_q.pop_front();
          if (e.bad) begin
            n_bad = n_bad + 1;
          end else if (e.act == ACT_TO_SERIAL) begin
            n_to_ser = n_to_ser + 1;
          end else begin
            n_to_date = n_to_date + 1;
          end
          if (m_tdata[16:0] !== e.serial) begin
            report_mismatch($sformatf("serial_out %0d, want %0d", m_tdata[16:0], e.serial));
          end
          if (m_tdata[41:17] !== e.date) begin
            report_mismatch($sformatf("date_out %0d, want %0d", m_tdata[41:17], e.date));
          end
          if (m_tuser !== e.bad) begin
            report_mismatch($sformatf("bad_input %b, want %b", m_tuser, e.bad));
          end
          if (m_tdata[47:42] !== 6'b0) begin
            report_mismatch($sformatf("tdata pad %b not zero", m_tdata[47:42]));
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap  <= snk_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap  <= $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // hard stop if the handshake ever locks up
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  task automatic add_date(input int unsigned pd);
    word_t w;
    w.act   = ACT_TO_SERIAL;
    w.pd    = pd[24:0];
    w.ser   = 17'($urandom_range(0, 131071));   // ignored field, keep it moving
    w.drain = 1'b0;
    pend_q.insert(pend_q.size(), w);
  endtask

  task automatic add_serial(input int unsigned ser);
    word_t w;
    w.act   = ACT_TO_DATE;
    w.pd    = 25'($urandom_range(0, 33554431));
    w.ser   = ser[16:0];
    w.drain = 1'b0;
    pend_q.insert(pend_q.size(), w);
  endtask

  initial begin
    int unsigned yr, mo, dy, sel;

    // directed: range ends, cycle and year boundaries, the 1900 leap day
    add_date(19000101);
    add_date(19000228);
    add_date(19000229);
    add_date(19000301);
    add_date(19001231);
    add_date(19031231);
    add_date(19040101);
    add_date(20991231);
    add_date(19000231);   // day past month end rolls into March
    add_date(18991231);   // year below range
    add_date(21000101);   // year above range
    add_date(19000001);   // month zero
    add_date(19001301);   // month thirteen
    add_date(19000100);   // day zero
    add_date(19000132);   // day 32
    add_date(0);
    add_date(33554431);
    add_serial(0);        // 1899-12-31, out of range
    add_serial(1);
    add_serial(60);
    add_serial(366);
    add_serial(1461);
    add_serial(1462);
    add_serial(73050);
    add_serial(73051);
    add_serial(131071);

    // random: mostly well-formed dates and serials, some junk
    for (int i = 0; i < RAND_WORDS; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9) begin
        yr = $urandom_range(1900, 2099);
        mo = $urandom_range(1, 12);
        dy = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
        add_date(yr * 10000 + mo * 100 + dy);
      end else if (sel < 10) begin
        add_date($urandom_range(0, 33554431));
      end else if (sel < 11) begin
        yr = $urandom_range(1890, 2110);
        add_date(yr * 10000 + $urandom_range(0, 99) * 100 + $urandom_range(0, 99));
      end else if (sel < 19) begin
        add_serial($urandom_range(1, 73050));
      end else begin
        add_serial($urandom_range(0, 131071));
      end
      if (i == 0 || i % DRAIN_EVERY == 0) begin
        pend_q[pend_q.size() - 1].drain = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // everything sent and every result back, then a tail for strays;
    // sampled mid-cycle so the clocked blocks have settled
    do begin
      @(negedge clk);
    end while (pend_q.size() != 0 || s_tvalid || sent_cnt != got_cnt);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (conv_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came", conv_q.size()));
    end

    $display("run: %0d words, %0d date-to-serial, %0d serial-to-date, %0d flagged bad",
             got_cnt, n_to_ser, n_to_date, n_bad);
    $display("run: random stalls on both sides, drain pauses, %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ddsc_pkg.sv
rtl/ddsc_divide.sv
rtl/ddsc_locate.sv
rtl/ddsc_assemble.sv
rtl/date_day_serial_converter_unit.sv
bench/tb_top.sv
